>>> hw/rtl/particle_euler_integrator_assert.svh
// ----------------------------------------------------------------------------
// particle euler integrator assertion macros
// concurrent checks that compile away in synthesis builds
// ----------------------------------------------------------------------------
`ifndef PARTICLE_EULER_INTEGRATOR_ASSERT_SVH
`define PARTICLE_EULER_INTEGRATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PEI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pei assertion failed");
// next-cycle implication
`define PEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pei assertion failed");
`else
`define PEI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PEI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/pei_pkg.sv
// ----------------------------------------------------------------------------
// pei_pkg
// shared types and constants of the particle euler integrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pei_pkg;

	localparam int WORD_W    = 32;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_FORCE_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_FORCE_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_DT    = 3'd4;

	// register reset values
	localparam logic [WORD_W-1:0] GRAVITY_X_RST   = '0;
	localparam logic [WORD_W-1:0] GRAVITY_Y_RST   = WORD_W'(-32'sd642252);
	localparam logic [WORD_W-1:0] EXT_FORCE_X_RST = '0;
	localparam logic [WORD_W-1:0] EXT_FORCE_Y_RST = '0;
	localparam logic [WORD_W-1:0] FRAME_DT_RST    = WORD_W'(32'd1092);

	// status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_SAT       = 2'd1;
	localparam logic [1:0] STATUS_ZERO_MASS = 2'd2;

	typedef struct packed {
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] vel_x;
		logic signed [WORD_W-1:0] vel_y;
		logic signed [WORD_W-1:0] force_x;
		logic signed [WORD_W-1:0] force_y;
		logic        [WORD_W-1:0] mass;
		logic                     last_in;
	} pei_in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] new_pos_x;
		logic signed [WORD_W-1:0] new_pos_y;
		logic signed [WORD_W-1:0] new_vel_x;
		logic signed [WORD_W-1:0] new_vel_y;
		logic        [1:0]        status;
		logic                     last_out;
	} pei_out_t;

endpackage

>>> hw/rtl/particle_euler_integrator.sv
// ----------------------------------------------------------------------------
// particle_euler_integrator
// semi-implicit euler step for a stream of independent 2d particles
// ----------------------------------------------------------------------------
// One particle is taken on every clock edge where start is high; busy never
// rises, so a new particle may follow in the very next cycle. Each particle
// comes back exactly once, in order, as one cycle of done with result (data
// in Q16.16 at the default FRAC_BITS). The force/mass divider resolves one
// quotient bit per pipeline stage; each other stage holds one multiply,
// rounding, add or clamp. done cannot be held off: the receiver must take
// every result in the cycle it is shown. The user must write registers
// through cfg_wr_en/cfg_index/cfg_data only while no particle is in flight;
// the block does not enforce it, and a write to an unknown index is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "particle_euler_integrator_assert.svh"

module particle_euler_integrator import pei_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pei_in_t              item,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output logic                 done,
	output pei_out_t             result
);

	// axis pipeline depth: 3 force stages, divider entry plus one stage per
	// quotient bit, 7 update stages
	localparam int AXIS_LAT = 11 + WORD_W + FRAC_BITS;
	// plus the result register
	localparam int OUT_LAT  = AXIS_LAT + 1;

	// configuration registers
	logic [WORD_W-1:0] gravity_x_q;
	logic [WORD_W-1:0] gravity_y_q;
	logic [WORD_W-1:0] ext_force_x_q;
	logic [WORD_W-1:0] ext_force_y_q;
	logic [WORD_W-1:0] frame_dt_q;

	// valid, frame marker and zero-mass flag travel beside the axis pipelines
	logic [AXIS_LAT-1:0] vld_line_q;
	logic [AXIS_LAT-1:0] last_line_q;
	logic [AXIS_LAT-1:0] zero_line_q;

	logic              accept;
	logic [WORD_W-1:0] npos_x;
	logic [WORD_W-1:0] npos_y;
	logic [WORD_W-1:0] nvel_x;
	logic [WORD_W-1:0] nvel_y;
	logic              sat_x;
	logic              sat_y;

	logic              done_q;
	pei_out_t          result_q;

	// fully pipelined, never stalls the sender
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_x_q   <= GRAVITY_X_RST;
			gravity_y_q   <= GRAVITY_Y_RST;
			ext_force_x_q <= EXT_FORCE_X_RST;
			ext_force_y_q <= EXT_FORCE_Y_RST;
			frame_dt_q    <= FRAME_DT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GRAVITY_X: begin
					gravity_x_q <= cfg_data;
				end
				REG_GRAVITY_Y: begin
					gravity_y_q <= cfg_data;
				end
				REG_EXT_FORCE_X: begin
					ext_force_x_q <= cfg_data;
				end
				REG_EXT_FORCE_Y: begin
					ext_force_y_q <= cfg_data;
				end
				REG_FRAME_DT: begin
					frame_dt_q <= cfg_data;
				end
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// x axis
	pei_axis #(
		.FRAC_BITS (FRAC_BITS)
	) u_axis_x (
		.clk     (clk),
		.pos     (item.pos_x),
		.vel     (item.vel_x),
		.frc     (item.force_x),
		.mass    (item.mass),
		.grav    (gravity_x_q),
		.ext_frc (ext_force_x_q),
		.dt      (frame_dt_q),
		.new_pos (npos_x),
		.new_vel (nvel_x),
		.sat     (sat_x)
	);

	// y axis
	pei_axis #(
		.FRAC_BITS (FRAC_BITS)
	) u_axis_y (
		.clk     (clk),
		.pos     (item.pos_y),
		.vel     (item.vel_y),
		.frc     (item.force_y),
		.mass    (item.mass),
		.grav    (gravity_y_q),
		.ext_frc (ext_force_y_q),
		.dt      (frame_dt_q),
		.new_pos (npos_y),
		.new_vel (nvel_y),
		.sat     (sat_y)
	);

	// valid line, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_line_q <= '0;
			done_q     <= 1'b0;
		end else begin
			vld_line_q <= {vld_line_q[AXIS_LAT-2:0], accept};
			done_q     <= vld_line_q[AXIS_LAT-1];
		end
	end

	// sideband payload and result register
	always_ff @(posedge clk) begin
		last_line_q <= {last_line_q[AXIS_LAT-2:0], item.last_in};
		zero_line_q <= {zero_line_q[AXIS_LAT-2:0], item.mass == '0};

		result_q.new_pos_x <= npos_x;
		result_q.new_pos_y <= npos_y;
		result_q.new_vel_x <= nvel_x;
		result_q.new_vel_y <= nvel_y;
		result_q.last_out  <= last_line_q[AXIS_LAT-1];
		if (zero_line_q[AXIS_LAT-1]) begin
			result_q.status <= STATUS_ZERO_MASS;
		end else if (sat_x || sat_y) begin
			result_q.status <= STATUS_SAT;
		end else begin
			result_q.status <= STATUS_OK;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// every result belongs to an earlier transfer
	`PEI_ASSERT_IMPLIES(a_done_has_transfer, clk, arst_n, done, $past(start, OUT_LAT))
	// a massless particle comes back untouched with its own status
	`PEI_ASSERT_IMPLIES(a_zero_mass_passes, clk, arst_n, done && ($past(item.mass, OUT_LAT) == '0), (result.status == STATUS_ZERO_MASS) && (result.new_vel_y == $past(item.vel_y, OUT_LAT)) && (result.new_pos_x == $past(item.pos_x, OUT_LAT)))
	// a clamp status only for a particle with mass
	`PEI_ASSERT_IMPLIES(a_sat_needs_mass, clk, arst_n, done && (result.status == STATUS_SAT), $past(item.mass, OUT_LAT) != '0)

endmodule

>>> hw/rtl/pei_axis.sv
// ----------------------------------------------------------------------------
// pei_axis
// one axis of the integrator: force sum, pipelined divide, two euler updates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pei_axis import pei_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic [WORD_W-1:0] pos,
	input  logic [WORD_W-1:0] vel,
	input  logic [WORD_W-1:0] frc,
	input  logic [WORD_W-1:0] mass,
	input  logic [WORD_W-1:0] grav,
	input  logic [WORD_W-1:0] ext_frc,
	input  logic [WORD_W-1:0] dt,
	output logic [WORD_W-1:0] new_pos,
	output logic [WORD_W-1:0] new_vel,
	output logic              sat
);

	localparam int W  = WORD_W;
	localparam int N  = W + FRAC_BITS;
	localparam int PW = 2 * W + 1;

	localparam logic [PW-1:0] RND_C   = PW'(1) << (FRAC_BITS - 1);
	localparam logic [W-1:0]  MAX_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MIN_MAG = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [W-1:0] pos;
		logic [W-1:0] vel;
		logic [W-1:0] mass;
		logic         zero;
		logic         sat;
		logic         neg;
	} ctx_t;

	// context of the next stage with a new clamp flag folded in
	function automatic ctx_t add_sat(input ctx_t c, input logic s);
		ctx_t r;
		r     = c;
		r.sat = c.sat | s;
		return r;
	endfunction

	// context of the next stage with the sign of the force
	function automatic ctx_t set_neg(input ctx_t c, input logic n);
		ctx_t r;
		r     = c;
		r.neg = n;
		return r;
	endfunction

	// clamp a magnitude, apply sign; msb of result is the clamp flag
	function automatic logic [W:0] sat_mag(input logic neg, input logic [PW-1:0] mag);
		logic [W-1:0] lim;
		logic [W-1:0] res;
		logic         ovf;
		lim = neg ? MIN_MAG : MAX_POS;
		ovf = mag > PW'(lim);
		res = ovf ? lim : mag[W-1:0];
		return {ovf, neg ? -res : res};
	endfunction

	// round half away from zero on the magnitude, then clamp
	function automatic logic [W:0] round_sat(input logic neg, input logic [2*W-1:0] prod);
		logic [PW-1:0] sum;
		sum = {1'b0, prod} + RND_C;
		return sat_mag(neg, sum >> FRAC_BITS);
	endfunction

	function automatic logic [W:0] sat_add(input logic [W+1:0] s);
		logic ovf;
		ovf = !((s[W+1:W-1] == 3'b000) || (s[W+1:W-1] == 3'b111));
		return {ovf, ovf ? (s[W+1] ? MIN_MAG : MAX_POS) : s[W-1:0]};
	endfunction

	function automatic logic [W-1:0] abs_w(input logic [W-1:0] x);
		return x[W-1] ? -x : x;
	endfunction

	function automatic logic [W+1:0] sx2(input logic [W-1:0] x);
		return {{2{x[W-1]}}, x};
	endfunction

	// stage registers
	logic [2*W-1:0] gm_prod_s1;
	logic           gneg_s1;
	logic [W-1:0]   frc_s1;
	ctx_t           ctx_s1;
	logic [W-1:0]   gm_s2;
	logic [W-1:0]   frc_s2;
	ctx_t           ctx_s2;
	logic [W-1:0]   f_s3;
	ctx_t           ctx_s3;
	logic [N-1:0]   div_nq_s  [0:N];
	logic [W-1:0]   div_rem_s [0:N];
	ctx_t           div_ctx_s [0:N];
	logic [W-1:0]   a_s5;
	ctx_t           ctx_s5;
	logic [2*W-1:0] ad_prod_s6;
	logic           aneg_s6;
	ctx_t           ctx_s6;
	logic [W-1:0]   ad_s7;
	ctx_t           ctx_s7;
	logic [W-1:0]   v_s8;
	ctx_t           ctx_s8;
	logic [2*W-1:0] vd_prod_s9;
	logic           vneg_s9;
	logic [W-1:0]   v_s9;
	ctx_t           ctx_s9;
	logic [W-1:0]   vd_s10;
	logic [W-1:0]   v_s10;
	ctx_t           ctx_s10;
	logic [W-1:0]   new_pos_s11;
	logic [W-1:0]   new_vel_s11;
	logic           sat_s11;

	// combinational results
	logic [W:0]     gm_c;
	logic [W:0]     f_c;
	logic [W:0]     a_c;
	logic [W:0]     ad_c;
	logic [W:0]     v_c;
	logic [W:0]     vd_c;
	logic [W:0]     p_c;
	logic [W:0]     trial_c [N];
	logic [W:0]     diff_c  [N];
	logic           ge_c    [N];

	always_comb begin
		gm_c = round_sat(gneg_s1, gm_prod_s1);
		f_c  = sat_add(sx2(frc_s2) + sx2(gm_s2) + sx2(ext_frc));
		a_c  = sat_mag(div_ctx_s[N].neg, PW'(div_nq_s[N]));
		ad_c = round_sat(aneg_s6, ad_prod_s6);
		v_c  = sat_add(sx2(ctx_s7.vel) + sx2(ad_s7));
		vd_c = round_sat(vneg_s9, vd_prod_s9);
		p_c  = sat_add(sx2(ctx_s10.pos) + sx2(vd_s10));
		// restoring divide, one quotient bit per stage
		for (int k = 0; k < N; k++) begin
			trial_c[k] = {div_rem_s[k], div_nq_s[k][N-1]};
			ge_c[k]    = trial_c[k] >= {1'b0, div_ctx_s[k].mass};
			diff_c[k]  = trial_c[k] - {1'b0, div_ctx_s[k].mass};
		end
	end

	always_ff @(posedge clk) begin
		// s1: gravity times mass
		gm_prod_s1  <= abs_w(grav) * mass;
		gneg_s1     <= grav[W-1];
		frc_s1      <= frc;
		ctx_s1.pos  <= pos;
		ctx_s1.vel  <= vel;
		ctx_s1.mass <= mass;
		ctx_s1.zero <= mass == '0;
		ctx_s1.sat  <= 1'b0;
		ctx_s1.neg  <= 1'b0;

		// s2: round the gravity term
		gm_s2  <= gm_c[W-1:0];
		frc_s2 <= frc_s1;
		ctx_s2 <= add_sat(ctx_s1, gm_c[W]);

		// s3: total force
		f_s3   <= f_c[W-1:0];
		ctx_s3 <= add_sat(ctx_s2, f_c[W]);

		// divider entry: rounded numerator
		div_nq_s[0]  <= {abs_w(f_s3), {FRAC_BITS{1'b0}}} + N'(ctx_s3.mass >> 1);
		div_rem_s[0] <= '0;
		div_ctx_s[0] <= set_neg(ctx_s3, f_s3[W-1]);

		for (int k = 0; k < N; k++) begin
			div_nq_s[k+1]  <= {div_nq_s[k][N-2:0], ge_c[k]};
			div_rem_s[k+1] <= ge_c[k] ? diff_c[k][W-1:0] : trial_c[k][W-1:0];
			div_ctx_s[k+1] <= div_ctx_s[k];
		end

		// s5: clamp acceleration
		a_s5   <= a_c[W-1:0];
		ctx_s5 <= add_sat(div_ctx_s[N], a_c[W]);

		// s6: accel times dt
		ad_prod_s6 <= abs_w(a_s5) * dt;
		aneg_s6    <= a_s5[W-1];
		ctx_s6     <= ctx_s5;

		// s7
		ad_s7  <= ad_c[W-1:0];
		ctx_s7 <= add_sat(ctx_s6, ad_c[W]);

		// s8: new velocity
		v_s8   <= v_c[W-1:0];
		ctx_s8 <= add_sat(ctx_s7, v_c[W]);

		// s9: new velocity times dt
		vd_prod_s9 <= abs_w(v_s8) * dt;
		vneg_s9    <= v_s8[W-1];
		v_s9       <= v_s8;
		ctx_s9     <= ctx_s8;

		// s10
		vd_s10  <= vd_c[W-1:0];
		v_s10   <= v_s9;
		ctx_s10 <= add_sat(ctx_s9, vd_c[W]);

		// s11: new position, zero mass passes the particle through
		new_pos_s11 <= ctx_s10.zero ? ctx_s10.pos : p_c[W-1:0];
		new_vel_s11 <= ctx_s10.zero ? ctx_s10.vel : v_s10;
		sat_s11     <= !ctx_s10.zero && (ctx_s10.sat || p_c[W]);
	end

	assign new_pos = new_pos_s11;
	assign new_vel = new_vel_s11;
	assign sat     = sat_s11;

endmodule
